@@ rtl/mts_pkg.sv @@
// Shared types, codes and constant score tables of the melody tone sequencer.
// No dependencies; every other file imports this package.
package mts_pkg;

	localparam int SCORE_LENGTH  = 24;
	localparam int PITCH_ENTRIES = 15;
	localparam int SCORE_IW      = $clog2(SCORE_LENGTH);
	localparam int PITCH_IW      = $clog2(PITCH_ENTRIES);

	localparam int TEMPO_W   = 14;
	localparam int BURST_W   = 12;
	localparam int DUR_W     = 3;
	localparam int PERIOD_W  = 7;
	localparam int DCOUNT_W  = 16;
	localparam int LIMIT_W   = TEMPO_W + DUR_W;
	localparam int CMD_W     = 8;
	localparam int POS_W     = 5;
	localparam int APB_DW    = 32;
	localparam int APB_AW    = 3;

	localparam logic [TEMPO_W-1:0] TEMPO_RESET = TEMPO_W'(1200);
	localparam logic [BURST_W-1:0] BURST_RESET = BURST_W'(1999);

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_CMD  = 1'b1;

	localparam logic [CMD_W-1:0] CMD_PLAY       = 8'd1;
	localparam logic [CMD_W-1:0] CMD_STOP       = 8'd2;
	localparam logic [CMD_W-1:0] CODE_BURST_LO  = 8'd3;
	localparam logic [CMD_W-1:0] CODE_BURST_HI  = 8'd6;
	localparam logic [CMD_W-1:0] CODE_BURST_ALT = 8'd8;
	localparam logic [CMD_W-1:0] CODE_BURST_END = 8'd9;

	localparam logic REG_TEMPO = 1'b0;
	localparam logic REG_BURST = 1'b1;

	localparam logic [PERIOD_W-1:0] PITCH_PERIOD [PITCH_ENTRIES] = '{
		7'd0, 7'd64, 7'd57, 7'd51, 7'd46, 7'd43, 7'd38, 7'd34,
		7'd32, 7'd29, 7'd25, 7'd22, 7'd21, 7'd19, 7'd17
	};

	localparam logic [PITCH_IW-1:0] SCORE_PITCH [SCORE_LENGTH] = '{
		4'd6, 4'd10, 4'd12, 4'd10, 4'd6, 4'd9, 4'd6, 4'd8, 4'd6, 4'd8, 4'd10, 4'd10,
		4'd9, 4'd10, 4'd8, 4'd6, 4'd10, 4'd12, 4'd13, 4'd13, 4'd13, 4'd10, 4'd13, 4'd0
	};

	localparam logic [DUR_W-1:0] SCORE_DUR [SCORE_LENGTH] = '{
		3'd4, 3'd2, 3'd1, 3'd2, 3'd2, 3'd4, 3'd1, 3'd1, 3'd1, 3'd1, 3'd4, 3'd1,
		3'd1, 3'd1, 3'd1, 3'd4, 3'd2, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd4, 3'd4
	};

	typedef struct packed {
		logic [PERIOD_W-1:0] count;
		logic                flip;
	} toggle_t;

	// Rest when the index falls past the table.
	function automatic logic [PERIOD_W-1:0] pitch_lookup(input logic [PITCH_IW-1:0] idx);
		logic [PERIOD_W-1:0] p;
		p = '0;
		if (int'(idx) < PITCH_ENTRIES) begin
			p = PITCH_PERIOD[idx];
		end
		return p;
	endfunction

	// Half-period toggler: count up, flip the level at half the period.
	function automatic toggle_t toggle_step(input logic [PERIOD_W-1:0] count,
			input logic [PERIOD_W-1:0] period);
		toggle_t r;
		r.count = count;
		r.flip  = 1'b0;
		if (period != '0) begin
			r.count = count + PERIOD_W'(1);
			if (r.count >= (period >> 1)) begin
				r.flip  = 1'b1;
				r.count = '0;
			end
		end
		return r;
	endfunction

endpackage

@@ rtl/mts_in_if.sv @@
// Input channel of the melody tone sequencer: ticks and command bytes.
// Depends on mts_pkg.
interface mts_in_if import mts_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             kind;
	logic [CMD_W-1:0] cmd_byte;

	modport source (output valid, kind, cmd_byte, input ready);
	modport sink   (input valid, kind, cmd_byte, output ready);
endinterface

@@ rtl/mts_out_if.sv @@
// Result channel of the melody tone sequencer: buzzer level and status.
// Depends on mts_pkg.
interface mts_out_if import mts_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             buzzer_level;
	logic             playing;
	logic [POS_W-1:0] score_position;
	logic             burst_active;

	modport source (output valid, buzzer_level, playing, score_position, burst_active,
		input ready);
	modport sink   (input valid, buzzer_level, playing, score_position, burst_active,
		output ready);
endinterface

@@ rtl/melody_tone_sequencer.sv @@
// Top level of the melody tone sequencer: score player, tone bursts, APB registers.
// Depends on mts_pkg, mts_in_if and mts_out_if.

// The block takes one beat per clock cycle on the items channel, a time tick or a
// command byte, while the results channel is not stalled, and returns exactly one
// result beat for each, held first in the input register and then in the result
// register. The whole state update of an item, including the note-length
// product and the half-period compare, sits between those two registers, so that
// update sets the sustained rate of one item per cycle. A stalled result register
// holds the input register too; ready drops only when both are full and the sink
// is stalled. Byte 1 starts the score, byte 2 stops it, and any byte is kept as the
// pending code; with the score stopped, codes 3 to 6, 8 and 9 sound a burst of
// burst_length ticks. Registers: tempo_unit at byte address 0, burst_length at 4.
// Write them only while no beat is in flight.
module melody_tone_sequencer import mts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	mts_in_if.sink            items,
	mts_out_if.source         results,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	// Configuration registers
	logic [TEMPO_W-1:0] tempo_q;
	logic [BURST_W-1:0] burst_len_q;

	// Sequencer state
	logic                level_q;
	logic                play_q;
	logic [CMD_W-1:0]    pending_q;
	logic [SCORE_IW-1:0] note_q;
	logic [DCOUNT_W-1:0] dur_count_q;
	logic [PERIOD_W-1:0] mel_half_q;
	logic [PERIOD_W-1:0] bst_half_q;
	logic [BURST_W-1:0]  bst_left_q;
	logic [PERIOD_W-1:0] bst_period_q;

	// Input register
	logic             valid_s1;
	logic             kind_s1;
	logic [CMD_W-1:0] cmd_s1;

	// Result register
	logic             valid_s2;
	logic             level_s2;
	logic             play_s2;
	logic [POS_W-1:0] pos_s2;
	logic             burst_s2;

	// Next state
	logic                level_d;
	logic                play_d;
	logic [CMD_W-1:0]    pending_d;
	logic [SCORE_IW-1:0] note_d;
	logic [DCOUNT_W-1:0] dur_count_d;
	logic [PERIOD_W-1:0] mel_half_d;
	logic [PERIOD_W-1:0] bst_half_d;
	logic [BURST_W-1:0]  bst_left_d;
	logic [PERIOD_W-1:0] bst_period_d;

	logic                s2_take;
	logic                s1_move;
	logic                cfg_write;
	logic                code_ok;
	logic [PITCH_IW-1:0] burst_pidx;
	logic [PERIOD_W-1:0] bst_period_cur;
	logic [BURST_W-1:0]  bst_left_cur;
	logic [PERIOD_W-1:0] mel_period;
	logic [LIMIT_W-1:0]  note_limit;
	logic [DCOUNT_W-1:0] dur_inc;
	toggle_t             bst_tog;
	toggle_t             mel_tog;

	// ---------------------------------------------------------------- APB
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		case (paddr[2])
			REG_TEMPO: prdata = APB_DW'(tempo_q);
			REG_BURST: prdata = APB_DW'(burst_len_q);
			default:   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tempo_q     <= TEMPO_RESET;
			burst_len_q <= BURST_RESET;
		end else if (cfg_write) begin
			case (paddr[2])
				REG_TEMPO: tempo_q     <= pwdata[TEMPO_W-1:0];
				REG_BURST: burst_len_q <= pwdata[BURST_W-1:0];
				default:   tempo_q     <= tempo_q;
			endcase
		end
	end

	// ---------------------------------------------------------------- flow control
	// The result register empties or drains; the input register moves on with it.
	assign s2_take     = !valid_s2 || results.ready;
	assign s1_move     = valid_s1 && s2_take;
	assign items.ready = !valid_s1 || s2_take;

	// ---------------------------------------------------------------- burst decode
	always_comb begin
		code_ok    = 1'b0;
		burst_pidx = '0;
		if (pending_q >= CODE_BURST_LO && pending_q <= CODE_BURST_HI) begin
			code_ok    = 1'b1;
			burst_pidx = pending_q[PITCH_IW-1:0] + PITCH_IW'(3);
		end else if (pending_q == CODE_BURST_ALT || pending_q == CODE_BURST_END) begin
			code_ok    = 1'b1;
			burst_pidx = pending_q[PITCH_IW-1:0] + PITCH_IW'(2);
		end
	end

	// A running burst resumes its own pitch and count; a new one loads both.
	assign bst_period_cur = (bst_left_q != '0) ? bst_period_q : pitch_lookup(burst_pidx);
	assign bst_left_cur   = (bst_left_q != '0) ? bst_left_q : burst_len_q;
	assign bst_tog        = toggle_step(bst_half_q, bst_period_cur);

	// ---------------------------------------------------------------- melody decode
	// Pitch and length come from the note held before any advance.
	always_comb begin
		mel_period = '0;
		note_limit = '0;
		if (int'(note_q) < SCORE_LENGTH) begin
			mel_period = pitch_lookup(SCORE_PITCH[note_q]);
			note_limit = LIMIT_W'(SCORE_DUR[note_q]) * LIMIT_W'(tempo_q);
		end
	end

	assign dur_inc = dur_count_q + DCOUNT_W'(1);
	assign mel_tog = toggle_step(mel_half_q, mel_period);

	// ---------------------------------------------------------------- state update
	always_comb begin
		level_d      = level_q;
		play_d       = play_q;
		pending_d    = pending_q;
		note_d       = note_q;
		dur_count_d  = dur_count_q;
		mel_half_d   = mel_half_q;
		bst_half_d   = bst_half_q;
		bst_left_d   = bst_left_q;
		bst_period_d = bst_period_q;

		if (kind_s1 == KIND_CMD) begin
			// Keep every byte pending; only play and stop touch the flag.
			pending_d = cmd_s1;
			if (cmd_s1 == CMD_PLAY) begin
				play_d = 1'b1;
			end else if (cmd_s1 == CMD_STOP) begin
				play_d = 1'b0;
			end
		end else if (bst_left_q != '0 || (!play_q && code_ok)) begin
			// Burst tick, which also serves as the first tick of a new burst.
			bst_period_d = bst_period_cur;
			bst_left_d   = bst_left_cur;
			if (bst_left_cur != '0) begin
				bst_half_d = bst_tog.count;
				level_d    = level_q ^ bst_tog.flip;
				bst_left_d = bst_left_cur - BURST_W'(1);
			end
			if (bst_left_d == '0) begin
				pending_d = '0;
			end
		end else if (play_q) begin
			// Melody tick: advance the note with wrap when its length runs out.
			dur_count_d = dur_inc;
			if (LIMIT_W'(dur_inc) >= note_limit) begin
				dur_count_d = '0;
				if (int'(note_q) >= SCORE_LENGTH - 1) begin
					note_d = '0;
				end else begin
					note_d = note_q + SCORE_IW'(1);
				end
			end
			mel_half_d = mel_tog.count;
			level_d    = level_q ^ mel_tog.flip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q      <= 1'b0;
			play_q       <= 1'b0;
			pending_q    <= '0;
			note_q       <= '0;
			dur_count_q  <= '0;
			mel_half_q   <= '0;
			bst_half_q   <= '0;
			bst_left_q   <= '0;
			bst_period_q <= '0;
		end else if (s1_move) begin
			level_q      <= level_d;
			play_q       <= play_d;
			pending_q    <= pending_d;
			note_q       <= note_d;
			dur_count_q  <= dur_count_d;
			mel_half_q   <= mel_half_d;
			bst_half_q   <= bst_half_d;
			bst_left_q   <= bst_left_d;
			bst_period_q <= bst_period_d;
		end
	end

	// ---------------------------------------------------------------- input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			kind_s1 <= items.kind;
			cmd_s1  <= items.cmd_byte;
		end
	end

	// ---------------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_take) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			level_s2 <= level_d;
			play_s2  <= play_d;
			pos_s2   <= POS_W'(note_d);
			burst_s2 <= (bst_left_d != '0);
		end
	end

	assign results.valid          = valid_s2;
	assign results.buzzer_level   = level_s2;
	assign results.playing        = play_s2;
	assign results.score_position = pos_s2;
	assign results.burst_active   = burst_s2;

`ifndef SYNTHESIS
	// Note index never leaves the score.
	a_note_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(note_q) < SCORE_LENGTH)
		else $error("note index past end of score");

	// A stalled result beat freezes the sequencer state.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !results.ready) |=>
		($stable(note_q) && $stable(bst_left_q) && $stable(level_q) && $stable(pending_q)))
		else $error("state moved while result stalled");

	// An empty result register always leaves the input side open.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> items.ready)
		else $error("input stalled with empty result register");

	// A running burst counts down by one on each tick taken.
	a_burst_count: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_move && kind_s1 == KIND_TICK && bst_left_q != '0) |=>
		(bst_left_q == $past(bst_left_q) - BURST_W'(1)))
		else $error("burst count did not step");
`endif

endmodule
